// ----- design/m4x4cm_pkg.sv -----
// ----------------------------------------------------------------------------
// m4x4cm_pkg
// Types and constants for the 4x4 matrix by column multiplier.
// ----------------------------------------------------------------------------
package m4x4cm_pkg;

	localparam int unsigned NUM_REGS      = 8;
	localparam int unsigned REG_W         = 64;
	localparam int unsigned ADDR_W        = 6;
	localparam int unsigned REG_IDX_W     = $clog2(NUM_REGS);
	localparam int unsigned ELEM_W        = 32;
	localparam int unsigned NUM_ELEMS     = 4;
	localparam int unsigned PROD_W        = 2 * ELEM_W;
	localparam int unsigned PAIR_W        = PROD_W + 1;
	localparam int unsigned SUM_W         = PROD_W + 2;
	localparam int unsigned DATA_W        = NUM_ELEMS * ELEM_W;
	localparam int unsigned FRAC_BITS_DEF = 16;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic        [REG_W-1:0]  reg_t;

	localparam reg_t REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
	};

	localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
	localparam elem_t ELEM_MIN = $signed(32'h8000_0000);
	localparam sum_t  SAT_HI   = sum_t'(ELEM_MAX);
	localparam sum_t  SAT_LO   = sum_t'(ELEM_MIN);

endpackage

// ----- design/matrix4x4_column_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix4x4_column_multiply
// Multiplies a configured 4x4 fixed-point matrix by a streamed column.
//
// The left-hand matrix A is written row-major over the APB port, eight 64-bit
// registers at byte addresses 0, 8, ... 56, each holding two signed elements
// with the lower-numbered one in the low half. Each request on the slave
// stream carries one column of the right-hand matrix; each request on the
// master stream carries the matching column of the product, saturated to the
// signed 32-bit range, with tuser set when any element was clipped.
// The datapath is four register stages: the sixteen products, pair sums, row
// sums, then shift and saturation into the output register. A column accepted
// on the slave side passes through them in order to the master side, and one
// column can be taken in every cycle while m_tready stays high. When the
// receiver stalls, the stages fill up behind the output register and s_tready
// falls only once all four hold data; nothing is dropped or repeated. Reset
// empties the pipeline and loads A with the identity matrix.
// ----------------------------------------------------------------------------
module matrix4x4_column_multiply #(
	parameter int unsigned FRAC_BITS = m4x4cm_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [m4x4cm_pkg::ADDR_W-1:0]  paddr,
	input  logic [m4x4cm_pkg::REG_W-1:0]   pwdata,
	output logic [m4x4cm_pkg::REG_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// col_elem0, col_elem1, col_elem2, col_elem3 from bit 0 up.
	input  logic [m4x4cm_pkg::DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_elem0, out_elem1, out_elem2, out_elem3 from bit 0 up.
	output logic [m4x4cm_pkg::DATA_W-1:0]  m_tdata,
	// saturated.
	output logic                           m_tuser
);

	import m4x4cm_pkg::*;

	reg_t  cfg_q [NUM_REGS];
	logic  cfg_wr;
	elem_t col_in [NUM_ELEMS];

	prod_t prod_d  [NUM_ELEMS*NUM_ELEMS];
	prod_t prod_s1 [NUM_ELEMS*NUM_ELEMS];
	pair_t pair_d  [NUM_ELEMS*2];
	pair_t pair_s2 [NUM_ELEMS*2];
	sum_t  rsum_d  [NUM_ELEMS];
	sum_t  rsum_s3 [NUM_ELEMS];
	sum_t  shr     [NUM_ELEMS];
	elem_t elem_d  [NUM_ELEMS];
	elem_t elem_s4 [NUM_ELEMS];
	logic  [NUM_ELEMS-1:0] clip;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic sat_s4;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = cfg_q[paddr[ADDR_W-1 -: REG_IDX_W]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_wr) begin
			cfg_q[paddr[ADDR_W-1 -: REG_IDX_W]] <= pwdata;
		end
	end

	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	for (genvar c = 0; c < NUM_ELEMS; c++) begin : g_col
		assign col_in[c] = elem_t'(s_tdata[c*ELEM_W +: ELEM_W]);
	end

	for (genvar r = 0; r < NUM_ELEMS; r++) begin : g_row
		for (genvar c = 0; c < NUM_ELEMS; c++) begin : g_prod
			elem_t a_w;
			assign a_w = elem_t'(cfg_q[r*2 + c/2][(c%2)*ELEM_W +: ELEM_W]);
			assign prod_d[r*NUM_ELEMS + c] = a_w * col_in[c];
		end
		for (genvar h = 0; h < 2; h++) begin : g_pair
			assign pair_d[r*2 + h] = pair_t'(prod_s1[r*NUM_ELEMS + 2*h])
				+ pair_t'(prod_s1[r*NUM_ELEMS + 2*h + 1]);
		end
		assign rsum_d[r] = sum_t'(pair_s2[r*2]) + sum_t'(pair_s2[r*2 + 1]);
		assign shr[r]    = rsum_s3[r] >>> FRAC_BITS;
		always_comb begin
			clip[r] = 1'b0;
			if (shr[r] > SAT_HI) begin
				elem_d[r] = ELEM_MAX;
				clip[r]   = 1'b1;
			end else if (shr[r] < SAT_LO) begin
				elem_d[r] = ELEM_MIN;
				clip[r]   = 1'b1;
			end else begin
				elem_d[r] = shr[r][ELEM_W-1:0];
			end
		end
		assign m_tdata[r*ELEM_W +: ELEM_W] = elem_s4[r];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			prod_s1 <= prod_d;
		end
		if (en_s2 && v_s1) begin
			pair_s2 <= pair_d;
		end
		if (en_s3 && v_s2) begin
			rsum_s3 <= rsum_d;
		end
		if (en_s4 && v_s3) begin
			elem_s4 <= elem_d;
			sat_s4  <= |clip;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tuser  = sat_s4;

	a_sat_extreme : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(elem_s4[0] == ELEM_MAX || elem_s4[0] == ELEM_MIN ||
			 elem_s4[1] == ELEM_MAX || elem_s4[1] == ELEM_MIN ||
			 elem_s4[2] == ELEM_MAX || elem_s4[2] == ELEM_MIN ||
			 elem_s4[3] == ELEM_MAX || elem_s4[3] == ELEM_MIN))
		else $error("saturation flag set without a clipped element");

	a_stall_source : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && v_s1 && v_s2 && v_s3))
		else $error("input stalled while the pipeline has room");

	a_s1_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en_s2) |=> (v_s1 && $stable(prod_s1[0])))
		else $error("first stage lost or changed a stalled column");

	a_out_source : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s3))
		else $error("result appeared without a column in the row-sum stage");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 matrix by column multiplier.
//
// The left-hand matrix is loaded over APB between phases while the stream is
// empty. Columns go in on the slave stream. Each accepted column is run
// through a local model of the fixed-point product: full-width sums, an
// arithmetic shift that rounds towards minus infinity, and saturation. The
// expected column is then queued. Every request on the master stream is
// compared field by field with the oldest queued column. Directed tests cover
// the identity matrix at reset, both kinds of overflow, the widest sums and
// the rounding of negative fractions. Random phases follow with fresh matrices
// and random stalls on both sides, and the run ends with a phase at full rate.
// ----------------------------------------------------------------------------
module tb_top;
	import m4x4cm_pkg::*;

	localparam int unsigned FRAC_BITS  = FRAC_BITS_DEF;
	localparam int unsigned PIPE_DEPTH = 4;
	localparam int unsigned RAND_PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 235;

	typedef enum int unsigned {
		ROW1_AB, ROW1_CD, ROW2_AB, ROW2_CD, ROW3_AB, ROW3_CD, ROW4_AB, ROW4_CD
	} row_reg_e;

	typedef enum int unsigned {
		MAT_RESET, MAT_ALL_ONES, MAT_ZERO, MAT_MAX, MAT_MIN, MAT_MODERATE, MAT_WILD
	} matrix_kind_e;

	typedef struct packed {
		logic              sat;
		logic [DATA_W-1:0] elems;
	} column_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [REG_W-1:0]  pwdata   = '0;
	logic [REG_W-1:0]  prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// col_elem0, col_elem1, col_elem2, col_elem3 from bit 0 up.
	logic [DATA_W-1:0] s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// out_elem0, out_elem1, out_elem2, out_elem3 from bit 0 up.
	logic [DATA_W-1:0] m_tdata;
	// saturated.
	logic              m_tuser;

	reg_t           matrix_regs [NUM_REGS];
	column_result_t product_q [$];
	logic           sender_idles  = 1'b0;
	logic           receiver_idles = 1'b0;
	int unsigned    columns_sent   = 0;
	int unsigned    columns_checked = 0;
	int unsigned    saturated_seen = 0;
	int unsigned    matrices_loaded = 0;
	int unsigned    mismatches     = 0;

	matrix4x4_column_multiply #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("matrix4x4_column_multiply verification failed");
		$finish;
	end

	function automatic column_result_t column_product(logic [DATA_W-1:0] col);
		column_result_t res;
		sum_t           acc;
		sum_t           shifted;
		elem_t          a;
		elem_t          b;
		res = '0;
		for (int r = 0; r < NUM_ELEMS; r++) begin
			acc = '0;
			for (int c = 0; c < NUM_ELEMS; c++) begin
				a = matrix_regs[r * 2 + c / 2][(c % 2) * ELEM_W +: ELEM_W];
				b = col[c * ELEM_W +: ELEM_W];
				acc = acc + sum_t'(a) * sum_t'(b);
			end
			shifted = acc >>> FRAC_BITS;
			if (shifted > SAT_HI) begin
				res.elems[r * ELEM_W +: ELEM_W] = ELEM_MAX;
				res.sat = 1'b1;
			end else if (shifted < SAT_LO) begin
				res.elems[r * ELEM_W +: ELEM_W] = ELEM_MIN;
				res.sat = 1'b1;
			end else begin
				res.elems[r * ELEM_W +: ELEM_W] = shifted[ELEM_W-1:0];
			end
		end
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] column(elem_t e0, elem_t e1, elem_t e2, elem_t e3);
		return {e3, e2, e1, e0};
	endfunction

	function automatic elem_t random_elem(int unsigned spread);
		case ($urandom_range(0, 9))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return elem_t'($urandom_range(0, 2)) - 1;
			3, 4: return $urandom;
			default: return elem_t'($urandom_range(0, (1 << spread) - 1)) - (1 << (spread - 1));
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s at %0t: expected %h, got %h", field, $realtime, want, got);
	endtask

	always @(posedge clk) begin : check_results
		column_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (product_q.size() == 0) begin
				report_mismatch("unexpected column", '0, m_tdata[63:0]);
			end else begin
				want = product_q.pop_front();
				columns_checked++;
				if (want.sat)
					saturated_seen++;
				for (int i = 0; i < NUM_ELEMS; i++) begin
					if (m_tdata[i * ELEM_W +: ELEM_W] !== want.elems[i * ELEM_W +: ELEM_W])
						report_mismatch($sformatf("out_elem%0d", i),
							64'(want.elems[i * ELEM_W +: ELEM_W]),
							64'(m_tdata[i * ELEM_W +: ELEM_W]));
				end
				if (m_tuser !== want.sat)
					report_mismatch("saturated", 64'(want.sat), 64'(m_tuser));
			end
		end
	end

	always begin
		@(negedge clk);
		if (receiver_idles && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	// Called and returning at a falling edge.
	task automatic send_column(logic [DATA_W-1:0] col);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= col;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		product_q.push_back(column_product(col));
		columns_sent++;
		@(negedge clk);
	endtask

	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (product_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	task automatic write_row_reg(row_reg_e idx, reg_t value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		matrix_regs[idx] = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_matrix(matrix_kind_e kind);
		reg_t value;
		settle_pipeline();
		for (int i = 0; i < NUM_REGS; i++) begin
			case (kind)
				MAT_RESET:    value = REG_RESET[i];
				MAT_ALL_ONES: value = '1;
				MAT_ZERO:     value = '0;
				MAT_MAX:      value = {ELEM_MAX, ELEM_MAX};
				MAT_MIN:      value = {ELEM_MIN, ELEM_MIN};
				MAT_MODERATE: value = {random_elem(19), random_elem(19)};
				default:      value = {$urandom, $urandom};
			endcase
			write_row_reg(row_reg_e'(i), value);
		end
		matrices_loaded++;
	endtask

	task automatic test_identity_at_reset();
		send_column(column(0, 1, -1, 32'sh0001_0000));
		send_column(column(ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN));
		send_column(column(ELEM_MIN, ELEM_MAX, -2, 32'sh5555_AAAA));
		send_column(column($urandom, $urandom, $urandom, $urandom));
	endtask

	task automatic test_overflow();
		load_matrix(MAT_MAX);
		send_column(column(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
		send_column(column(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
		send_column(column(ELEM_MAX, ELEM_MIN, 0, 1));
		load_matrix(MAT_MIN);
		send_column(column(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
		send_column(column(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
		send_column(column(0, 0, 0, 0));
		load_matrix(MAT_ALL_ONES);
		send_column(column(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
		send_column(column(-1, -1, -1, -1));
	endtask

	// Small negative sums must round down, not towards zero.
	task automatic test_negative_rounding();
		load_matrix(MAT_ZERO);
		write_row_reg(ROW1_AB, {32'h0000_0001, 32'h0000_0001});
		write_row_reg(ROW1_CD, {32'h0000_0001, 32'h0000_0001});
		write_row_reg(ROW2_AB, {32'h0000_0000, 32'h0000_8000});
		write_row_reg(ROW3_CD, {32'hFFFF_8000, 32'h0000_0000});
		write_row_reg(ROW4_CD, {32'h0000_0003, 32'h0000_0000});
		send_column(column(-1, -1, -1, -1));
		send_column(column(-3, 3, -3, -7));
		send_column(column(1, 1, 1, 1));
		send_column(column(-32'sh0001_0001, 5, 32'sh0000_0003, -1));
	endtask

	task automatic test_random_phases();
		matrix_kind_e kind;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: kind = MAT_RESET;
				1: kind = MAT_ALL_ONES;
				2: kind = MAT_WILD;
				default: kind = MAT_MODERATE;
			endcase
			if (p == RAND_PHASES - 1)
				kind = matrix_kind_e'($urandom_range(MAT_RESET, MAT_WILD));
			load_matrix(kind);
			sender_idles   = (p % 3) != 2;
			receiver_idles = (p % 4) != 3;
			if (p == RAND_PHASES - 1) begin
				sender_idles   = 1'b0;
				receiver_idles = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_column(column(random_elem(21), random_elem(21),
					random_elem(21), random_elem(21)));
				if ($urandom_range(0, 99) == 0)
					settle_pipeline();
			end
		end
	endtask

	initial begin
		foreach (matrix_regs[i])
			matrix_regs[i] = REG_RESET[i];
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		receiver_idles = 1'b1;
		test_identity_at_reset();
		sender_idles = 1'b1;
		test_overflow();
		test_negative_rounding();
		test_random_phases();

		settle_pipeline();
		$display("Checked %0d of %0d columns (%0d saturated) over %0d matrix settings.",
			columns_checked, columns_sent, saturated_seen, matrices_loaded);
		$display("Mismatches: %0d, columns still awaited: %0d.", mismatches, product_q.size());
		if (mismatches == 0 && product_q.size() == 0)
			$display("matrix4x4_column_multiply verification clean");
		else
			$display("matrix4x4_column_multiply verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/m4x4cm_pkg.sv
design/matrix4x4_column_multiply.sv
tb/tb_top.sv
